// ===== sv/fwnf_pkg.sv =====
// ----------------------------------------------------------------------------
// fwnf_pkg: shared definitions for the fixed-width number formatter
// Widths of the ports, the digit layout and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package fwnf_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 4;
    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 4;
    localparam int MAX_DIGITS  = 8;
    localparam int DIGITS_W    = MAX_DIGITS * DIGIT_W;
    localparam int IDX_W       = 3;
    localparam int STEP_W      = 5;

    localparam logic KIND_HEX  = 1'b0;
    localparam logic KIND_DEC  = 1'b1;

    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'hA;
    localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ   = 4'd3;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_UPPER_A = 7'h41;

    typedef logic [DIGITS_W-1:0] digits_t;

    // Maps a digit value to its ASCII character, upper case above nine.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d >= DIGIT_TEN)
        begin
            ch = ASCII_UPPER_A + CHAR_W'(d - DIGIT_TEN);
        end
        else
        begin
            ch = ASCII_ZERO + CHAR_W'(d);
        end
        return ch;
    endfunction

endpackage

// ===== sv/fixed_width_number_formatter_top.sv =====
// ----------------------------------------------------------------------------
// fixed_width_number_formatter_top: fixed-width hex/decimal ASCII formatter
// Formats a 32-bit unsigned value as exactly digit_count ASCII digits, most
// significant first, keeping leading zeros and dropping higher digits.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload                   Transfer
//  -------   ------------------   -----------------------   -----------------------
//  command   start / busy         kind, value, digit_count  edge with start & !busy
//  result    strobe (no stall)    character, last           every edge with strobe
//
// A hexadecimal number is loaded and its characters are then emitted on
// consecutive cycles. A decimal number is loaded, converted through the
// shared shift-and-add-three unit (one value bit per cycle), and its
// characters are then emitted on consecutive cycles.
// A count of zero or above eight is taken and produces no characters; busy
// never rises for it. Reset returns the sequencer to idle and clears strobe.
// The receiver cannot stall: characters leave on consecutive cycles.
// ----------------------------------------------------------------------------
module fixed_width_number_formatter_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                kind,
    input  logic [fwnf_pkg::VALUE_W-1:0]        value,
    input  logic [fwnf_pkg::COUNT_W-1:0]        digit_count,
    output logic                                strobe,
    output logic [fwnf_pkg::CHAR_W-1:0]         character,
    output logic                                last
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [fwnf_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [fwnf_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [fwnf_pkg::VALUE_W-1:0]     bin_reg, bin_next;
    fwnf_pkg::digits_t                digits_reg, digits_next;
    logic                             strobe_reg, strobe_next;
    logic                             last_reg, last_next;
    logic [fwnf_pkg::CHAR_W-1:0]      char_reg, char_next;

    fwnf_pkg::digits_t                step_digits;
    logic                             accept;
    logic                             count_ok;
    logic [fwnf_pkg::COUNT_W-1:0]     count_m1;
    logic [fwnf_pkg::DIGIT_W-1:0]     cur_digit;

    // The shared conversion unit: one value bit enters per cycle.
    fwnf_bcd_step u_bcd_step
    (
        .digits_in  (digits_reg),
        .bit_in     (bin_reg[fwnf_pkg::VALUE_W-1]),
        .digits_out (step_digits)
    );

    assign accept    = start && (state_reg == ST_IDLE);
    assign count_ok  = (digit_count != '0) &&
                       (digit_count <= fwnf_pkg::COUNT_W'(fwnf_pkg::MAX_DIGITS));
    assign count_m1  = digit_count - fwnf_pkg::COUNT_W'(1);
    assign cur_digit = digits_reg[{idx_reg, 2'b00} +: fwnf_pkg::DIGIT_W];

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        bin_next    = bin_reg;
        digits_next = digits_reg;
        strobe_next = 1'b0;
        last_next   = last_reg;
        char_next   = char_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && count_ok)
                begin
                    idx_next = count_m1[fwnf_pkg::IDX_W-1:0];
                    step_next = '0;
                    if (kind == fwnf_pkg::KIND_DEC)
                    begin
                        bin_next    = value;
                        digits_next = '0;
                        state_next  = ST_CONV;
                    end
                    else
                    begin
                        // Hex digits are simply the nibbles of the value.
                        digits_next = value[fwnf_pkg::DIGITS_W-1:0];
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_CONV:
            begin
                digits_next = step_digits;
                bin_next    = {bin_reg[fwnf_pkg::VALUE_W-2:0], 1'b0};
                step_next   = step_reg + fwnf_pkg::STEP_W'(1);
                if (step_reg == fwnf_pkg::STEP_W'(fwnf_pkg::VALUE_W - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                char_next   = fwnf_pkg::digit_to_ascii(cur_digit);
                last_next   = (idx_reg == '0);
                idx_next    = idx_reg - fwnf_pkg::IDX_W'(1);
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            step_reg   <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            step_reg   <= step_next;
            idx_reg    <= idx_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        bin_reg    <= bin_next;
        digits_reg <= digits_next;
        last_reg   <= last_next;
        char_reg   <= char_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // A character is only ever produced from the emit state.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == ST_EMIT))
        else $error("character strobe without emit state");

    // Characters of one number leave on consecutive cycles until the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside a formatted number");

    // An empty or oversized count is taken without entering the busy phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !count_ok) |=> !busy)
        else $error("busy raised for a count that emits nothing");

    // The final character always ends the busy phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("still busy after the last character");

endmodule

// ===== sv/fwnf_bcd_step.sv =====
// ----------------------------------------------------------------------------
// fwnf_bcd_step: one shift-and-add-three step of binary to BCD conversion
// Corrects every BCD digit of five or more by three, then shifts the digit
// word left by one, taking in the next binary bit.
// ----------------------------------------------------------------------------
module fwnf_bcd_step
(
    input  fwnf_pkg::digits_t digits_in,
    input  logic              bit_in,
    output fwnf_pkg::digits_t digits_out
);

    fwnf_pkg::digits_t adjusted;

    // Digits are independent; carries only move upward through the shift,
    // so the digits above the top one can be dropped without harm.
    always_comb
    begin
        for (int i = 0; i < fwnf_pkg::MAX_DIGITS; i++)
        begin
            if (digits_in[i*fwnf_pkg::DIGIT_W +: fwnf_pkg::DIGIT_W] >= fwnf_pkg::DIGIT_FIVE)
            begin
                adjusted[i*fwnf_pkg::DIGIT_W +: fwnf_pkg::DIGIT_W] =
                    digits_in[i*fwnf_pkg::DIGIT_W +: fwnf_pkg::DIGIT_W] + fwnf_pkg::DIGIT_ADJ;
            end
            else
            begin
                adjusted[i*fwnf_pkg::DIGIT_W +: fwnf_pkg::DIGIT_W] =
                    digits_in[i*fwnf_pkg::DIGIT_W +: fwnf_pkg::DIGIT_W];
            end
        end
    end

    assign digits_out = {adjusted[fwnf_pkg::DIGITS_W-2:0], bit_in};

endmodule

// ===== tb/tb_fixed_width_number_formatter_top.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_width_number_formatter_top: self-checking bench for the formatter
// Sends hexadecimal and decimal format commands, first from a short directed
// table and then at random in bursts with gaps. Every character the block
// strobes out is compared with the oldest entry of a queue of predicted
// characters, built by a local digit expander or typed into the table.
// ----------------------------------------------------------------------------
module tb_fixed_width_number_formatter_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 450;
    // Longest command is a decimal one: load, 32 conversion steps, 8 characters.
    localparam int WORST_LATENCY = 41;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 2 * WORST_LATENCY;
    localparam int DIRECTED_N    = 20;

    // One predicted character on the result side.
    typedef struct packed
    {
        logic [fwnf_pkg::CHAR_W-1:0] character;
        logic                        last;
    } char_t;

    // One row of the directed table. When typed is set, text holds the
    // expected characters as an ASCII string, least significant digit in the
    // low byte; otherwise the digit expander predicts the row.
    typedef struct packed
    {
        logic                         typed;
        logic                         kind;
        logic [fwnf_pkg::VALUE_W-1:0] value;
        logic [fwnf_pkg::COUNT_W-1:0] count;
        logic [63:0]                  text;
    } row_t;

    localparam row_t DIRECTED_ROWS [DIRECTED_N] = '{
        // Extremes of the value in both radixes at the full width.
        '{1'b1, fwnf_pkg::KIND_HEX, 32'h0000_0000, 4'd8,  "00000000"},
        '{1'b1, fwnf_pkg::KIND_HEX, 32'hFFFF_FFFF, 4'd8,  "FFFFFFFF"},
        '{1'b1, fwnf_pkg::KIND_DEC, 32'hFFFF_FFFF, 4'd8,  "94967295"},
        '{1'b1, fwnf_pkg::KIND_DEC, 32'h0000_0000, 4'd8,  "00000000"},
        // A zero count and counts above eight emit nothing at all.
        '{1'b1, fwnf_pkg::KIND_HEX, 32'hFFFF_FFFF, 4'd0,  64'h0},
        '{1'b1, fwnf_pkg::KIND_DEC, 32'd12345678,  4'd9,  64'h0},
        '{1'b1, fwnf_pkg::KIND_HEX, 32'hA5A5_A5A5, 4'd15, 64'h0},
        '{1'b1, fwnf_pkg::KIND_DEC, 32'h0000_0000, 4'd0,  64'h0},
        // Top bit set in decimal: read as unsigned, no minus sign.
        '{1'b1, fwnf_pkg::KIND_DEC, 32'h8000_0000, 4'd8,  "47483648"},
        // Single digits and truncation of the higher digits.
        '{1'b1, fwnf_pkg::KIND_HEX, 32'h89AB_CDEF, 4'd1,  "F"},
        '{1'b1, fwnf_pkg::KIND_DEC, 32'hFFFF_FFFF, 4'd1,  "5"},
        '{1'b1, fwnf_pkg::KIND_HEX, 32'h0123_ABCD, 4'd4,  "ABCD"},
        '{1'b1, fwnf_pkg::KIND_DEC, 32'd99999999,  4'd8,  "99999999"},
        '{1'b1, fwnf_pkg::KIND_DEC, 32'd100000000, 4'd8,  "00000000"},
        // Middle counts are left to the digit expander.
        '{1'b0, fwnf_pkg::KIND_HEX, 32'hDEAD_BEEF, 4'd5,  64'h0},
        '{1'b0, fwnf_pkg::KIND_DEC, 32'd12345678,  4'd3,  64'h0},
        '{1'b0, fwnf_pkg::KIND_HEX, 32'h7654_3210, 4'd7,  64'h0},
        '{1'b0, fwnf_pkg::KIND_DEC, 32'd4000000000, 4'd6, 64'h0},
        '{1'b0, fwnf_pkg::KIND_DEC, 32'd9876543,   4'd2,  64'h0},
        '{1'b0, fwnf_pkg::KIND_HEX, 32'h0F1E_2D3C, 4'd6,  64'h0}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         kind;
    logic [fwnf_pkg::VALUE_W-1:0] value;
    logic [fwnf_pkg::COUNT_W-1:0] digit_count;
    logic                         strobe;
    logic [fwnf_pkg::CHAR_W-1:0]  character;
    logic                         last;

    // Characters still owed by the block, oldest first.
    char_t pending_chars [$];
    char_t oldest_char;
    int    mismatch_count;

    fixed_width_number_formatter_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .value       (value),
        .digit_count (digit_count),
        .strobe      (strobe),
        .character   (character),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // Expands the value into count digits, least significant first, then
    // queues them most significant first with last on the final one.
    function automatic void expand_digits(input logic k,
                                          input logic [fwnf_pkg::VALUE_W-1:0] v,
                                          input logic [fwnf_pkg::COUNT_W-1:0] n);
        logic [fwnf_pkg::DIGIT_W-1:0] digit_lsb [fwnf_pkg::MAX_DIGITS];
        logic [fwnf_pkg::VALUE_W-1:0] rest;
        char_t                        ch;
        int                           i;
        if (n == 0 || n > fwnf_pkg::MAX_DIGITS)
        begin
            return;
        end
        rest = v;
        for (i = 0; i < n; i++)
        begin
            if (k == fwnf_pkg::KIND_DEC)
            begin
                digit_lsb[i] = fwnf_pkg::DIGIT_W'(rest % 10);
                rest         = rest / 10;
            end
            else
            begin
                digit_lsb[i] = rest[fwnf_pkg::DIGIT_W-1:0];
                rest         = rest >> fwnf_pkg::DIGIT_W;
            end
        end
        for (i = n - 1; i >= 0; i--)
        begin
            if (digit_lsb[i] > 4'd9)
            begin
                ch.character = fwnf_pkg::ASCII_UPPER_A + fwnf_pkg::CHAR_W'(digit_lsb[i])
                               - fwnf_pkg::CHAR_W'(10);
            end
            else
            begin
                ch.character = fwnf_pkg::ASCII_ZERO + fwnf_pkg::CHAR_W'(digit_lsb[i]);
            end
            ch.last = (i == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    // Queues the characters of a typed table row.
    function automatic void queue_typed_text(input logic [fwnf_pkg::COUNT_W-1:0] n,
                                             input logic [63:0] text);
        char_t ch;
        int    i;
        if (n == 0 || n > fwnf_pkg::MAX_DIGITS)
        begin
            return;
        end
        for (i = n - 1; i >= 0; i--)
        begin
            ch.character = text[i*8 +: fwnf_pkg::CHAR_W];
            ch.last      = (i == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    // Presents one command and waits for its transfer. Start is left high
    // so that the next command of a burst follows without a gap; the
    // caller lowers it when a gap is wanted.
    task automatic issue_command(input logic k, input logic [fwnf_pkg::VALUE_W-1:0] v,
                                 input logic [fwnf_pkg::COUNT_W-1:0] n);
        start       <= 1'b1;
        kind        <= k;
        value       <= v;
        digit_count <= n;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Result side. The block cannot be stalled, so every strobe is a
    // transfer and is checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character: 0x%0h last %0b", character, last);
                mismatch_count++;
            end
            else
            begin
                oldest_char = pending_chars.pop_front();
                if (character !== oldest_char.character)
                begin
                    $error("character: expected 0x%0h, actual 0x%0h",
                           oldest_char.character, character);
                    mismatch_count++;
                end
                if (last !== oldest_char.last)
                begin
                    $error("last: expected %0b, actual %0b", oldest_char.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random bursts, drain, verdict.
    initial
    begin
        int                           sent_count;
        int                           burst_left;
        int                           gap;
        int                           drain_cycles;
        int                           pick;
        logic                         r_kind;
        logic [fwnf_pkg::VALUE_W-1:0] r_value;
        logic [fwnf_pkg::COUNT_W-1:0] r_count;

        mismatch_count = 0;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        kind        <= fwnf_pkg::KIND_HEX;
        value       <= '0;
        digit_count <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, commands back to back. The queue is filled at the
        // transfer edge, always ahead of the first character of the command.
        for (int r = 0; r < DIRECTED_N; r++)
        begin
            issue_command(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].value,
                          DIRECTED_ROWS[r].count);
            if (DIRECTED_ROWS[r].typed)
            begin
                queue_typed_text(DIRECTED_ROWS[r].count, DIRECTED_ROWS[r].text);
            end
            else
            begin
                expand_digits(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].value,
                              DIRECTED_ROWS[r].count);
            end
        end

        // Random part. Commands go out in bursts; the gaps between bursts
        // range from nothing to longer than a whole decimal conversion so
        // that a new start lands on every phase of the block's work.
        sent_count = 0;
        burst_left = $urandom_range(1, 12);
        while (sent_count < RANDOM_ITEMS)
        begin
            r_kind = 1'($urandom_range(0, 1));

            // Mostly legal counts with the full width favored; about one
            // command in ten has a count that must produce nothing.
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                r_count = ($urandom_range(0, 3) == 0) ? 4'd0 :
                          fwnf_pkg::COUNT_W'($urandom_range(9, 15));
            end
            else if (pick < 4)
            begin
                r_count = fwnf_pkg::COUNT_W'(fwnf_pkg::MAX_DIGITS);
            end
            else
            begin
                r_count = fwnf_pkg::COUNT_W'($urandom_range(1, fwnf_pkg::MAX_DIGITS));
            end

            // Values: plain random, small, near all ones, single bits and
            // boundaries at and just below powers of ten.
            pick = $urandom_range(0, 7);
            case (pick)
                0: r_value = fwnf_pkg::VALUE_W'($urandom_range(0, 99));
                1: r_value = 32'hFFFF_FFFF - fwnf_pkg::VALUE_W'($urandom_range(0, 15));
                2: r_value = fwnf_pkg::VALUE_W'(1) << $urandom_range(0, fwnf_pkg::VALUE_W - 1);
                3:
                begin
                    r_value = 32'd1;
                    repeat ($urandom_range(1, 9)) r_value = r_value * 10;
                    r_value = r_value - fwnf_pkg::VALUE_W'($urandom_range(0, 2));
                end
                default: r_value = $urandom;
            endcase

            issue_command(r_kind, r_value, r_count);
            expand_digits(r_kind, r_value, r_count);
            sent_count++;

            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                pick = $urandom_range(0, 9);
                if (pick < 3)
                begin
                    gap = 0;
                end
                else if (pick < 7)
                begin
                    gap = $urandom_range(1, 6);
                end
                else
                begin
                    gap = $urandom_range(7, 45);
                end
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        start <= 1'b0;

        // Wait for every owed character, then a little longer so that any
        // stray extra strobe is still caught.
        drain_cycles = 0;
        while (pending_chars.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        if (pending_chars.size() != 0)
        begin
            $error("%0d characters never arrived", pending_chars.size());
            mismatch_count++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (about 470 commands of at most
    // a full decimal conversion each plus the longest gaps between bursts).
    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== fixed_width_number_formatter_top.f =====
sv/fwnf_pkg.sv
sv/fwnf_bcd_step.sv
sv/fixed_width_number_formatter_top.sv
tb/tb_fixed_width_number_formatter_top.sv
